/* design/pfl_pkg.sv */
// Shared types and sizing for the page-frame replacement table.
// No dependencies; imported by pfl_cell and page_replacement_fifo_lru.
package pfl_pkg;

  localparam int FRAMES    = 4;
  localparam int PAGE_BITS = 16;
  localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RANK_W    = IDX_W;
  localparam int PAGE_W    = PAGE_BITS;

  // Policy register values
  localparam logic POL_FIFO = 1'b0;
  localparam logic POL_LRU  = 1'b1;

  // Command codes
  localparam logic CMD_REF   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic [RANK_W-1:0] RANK_OLDEST = RANK_W'(FRAMES - 1);
  localparam logic [31:0]       FAULT_MAX   = 32'hFFFF_FFFF;

  // Broadcast to every cell for one request
  typedef struct packed {
    logic              clear;
    logic              upd;
    logic              miss;
    logic [PAGE_W-1:0] page;
    logic [RANK_W-1:0] tgt_rank;
  } cell_ctrl_t;

  // Collects the selected frame's contents along the row
  typedef struct packed {
    logic              vld;
    logic [RANK_W-1:0] rank;
    logic [PAGE_W-1:0] page;
  } gather_t;

endpackage

/* design/pfl_cell.sv */
// One frame of the replacement table: page, valid bit and recency rank.
// Depends on pfl_pkg; chained by page_replacement_fifo_lru.
module pfl_cell
  import pfl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [RANK_W-1:0] rank_init_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic              found_i,
  output logic              found_o,
  output logic              first_hit_o,
  output logic              oldest_o,
  input  logic              target_i,
  input  gather_t           gather_i,
  output gather_t           gather_o
);

  logic [PAGE_W-1:0] page_q, page_d;
  logic              valid_q, valid_d;
  logic [RANK_W-1:0] rank_q, rank_d;
  logic              match;

  assign match       = valid_q && (page_q == ctrl_i.page);
  assign first_hit_o = match && !found_i;
  assign found_o     = found_i || match;
  assign oldest_o    = (rank_q == RANK_OLDEST);

  always_comb begin
    gather_o = gather_i;
    if (target_i) begin
      gather_o.vld  = gather_i.vld  | valid_q;
      gather_o.rank = gather_i.rank | rank_q;
      gather_o.page = gather_i.page | (valid_q ? page_q : '0);
    end
  end

  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    page_d  = page_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
      rank_d  = rank_init_i;
    end else if (ctrl_i.upd) begin
      if (target_i) begin
        // move to most recent; refill on a miss
        rank_d  = '0;
        valid_d = 1'b1;
        if (ctrl_i.miss) begin
          page_d = ctrl_i.page;
        end
      end else if (rank_q < ctrl_i.tgt_rank) begin
        rank_d = rank_q + RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= rank_init_i;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

endmodule

/* design/page_replacement_fifo_lru.sv */
// Page-frame table with FIFO or LRU replacement, top level.
// Depends on pfl_pkg and pfl_cell.
//
// Usage: drive cmd_i and page_number_i with start high for one cycle to
// issue a request; it is taken at that edge when busy is low. busy stays
// low, so a request can be issued every cycle. cmd_i selects a page
// reference or a clear of all frames and the fault count.
// Each request yields one result in the following cycle: done_o is high for exactly
// one cycle with hit_o, frame_index_o, evicted_valid_o, evicted_page_o and
// fault_count_o. The receiver cannot stall; results must be taken as shown.
// Throughput 1 request per cycle: the match along the row of frame cells,
// the victim pick and the rank update are all combinational, their depth
// set by the length of the found/gather chain through the cells.
// policy_we_i/policy_wdata_i write the replacement policy (0 FIFO, 1 LRU);
// write it only while no request is in flight.
// Reset (rst_ni low) empties all frames, restores the rank order, zeroes the
// FIFO pointer and fault count, and selects FIFO.
module page_replacement_fifo_lru
  import pfl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  logic [15:0] page_number_i,
  input  logic        policy_we_i,
  input  logic        policy_wdata_i,
  output logic        done_o,
  output logic        hit_o,
  output logic [1:0]  frame_index_o,
  output logic        evicted_valid_o,
  output logic [15:0] evicted_page_o,
  output logic [31:0] fault_count_o
);

  logic              policy_q;
  logic [IDX_W-1:0]  fifo_ptr_q, fifo_ptr_d;
  logic [31:0]       faults_q, faults_d;
  logic              done_q;
  logic              hit_q, hit_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              ev_vld_q, ev_vld_d;
  logic [PAGE_W-1:0] ev_page_q, ev_page_d;

  logic              accept;
  logic              is_ref;
  logic              hit_any;
  logic [FRAMES-1:0] first_hit;
  logic [FRAMES-1:0] oldest;
  logic [FRAMES-1:0] target;
  logic [FRAMES:0]   found;
  gather_t           gather [FRAMES+1];
  cell_ctrl_t        ctrl;
  logic [IDX_W-1:0]  tgt_idx;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign is_ref = accept && (cmd_i == CMD_REF);

  assign found[0]  = 1'b0;
  assign gather[0] = '0;
  assign hit_any   = found[FRAMES];

  // Pick the frame to touch: the hit, else the policy's victim
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      if (hit_any) begin
        target[i] = first_hit[i];
      end else if (policy_q == POL_LRU) begin
        target[i] = oldest[i];
      end else begin
        target[i] = (fifo_ptr_q == IDX_W'(i));
      end
    end
  end

  always_comb begin
    tgt_idx = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (target[i]) begin
        tgt_idx = tgt_idx | IDX_W'(i);
      end
    end
  end

  always_comb begin
    ctrl.clear    = accept && (cmd_i == CMD_CLEAR);
    ctrl.upd      = is_ref;
    ctrl.miss     = !hit_any;
    ctrl.page     = PAGE_W'(page_number_i);
    ctrl.tgt_rank = gather[FRAMES].rank;
  end

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    pfl_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .rank_init_i (RANK_W'(FRAMES - 1 - g)),
      .ctrl_i      (ctrl),
      .found_i     (found[g]),
      .found_o     (found[g+1]),
      .first_hit_o (first_hit[g]),
      .oldest_o    (oldest[g]),
      .target_i    (target[g]),
      .gather_i    (gather[g]),
      .gather_o    (gather[g+1])
    );
  end

  always_comb begin
    fifo_ptr_d = fifo_ptr_q;
    faults_d   = faults_q;
    hit_d      = 1'b0;
    idx_d      = '0;
    ev_vld_d   = 1'b0;
    ev_page_d  = '0;
    if (ctrl.clear) begin
      fifo_ptr_d = '0;
      faults_d   = '0;
    end else if (is_ref) begin
      hit_d = hit_any;
      idx_d = tgt_idx;
      if (!hit_any) begin
        ev_vld_d  = gather[FRAMES].vld;
        ev_page_d = gather[FRAMES].page;
        if (faults_q != FAULT_MAX) begin
          faults_d = faults_q + 32'd1;
        end
        if (policy_q == POL_FIFO) begin
          // advance round robin
          if (fifo_ptr_q == IDX_W'(FRAMES - 1)) begin
            fifo_ptr_d = '0;
          end else begin
            fifo_ptr_d = fifo_ptr_q + IDX_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q   <= POL_FIFO;
      fifo_ptr_q <= '0;
      faults_q   <= '0;
      done_q     <= 1'b0;
    end else begin
      if (policy_we_i) begin
        policy_q <= policy_wdata_i;
      end
      fifo_ptr_q <= fifo_ptr_d;
      faults_q   <= faults_d;
      done_q     <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q     <= hit_d;
    idx_q     <= idx_d;
    ev_vld_q  <= ev_vld_d;
    ev_page_q <= ev_page_d;
  end

  assign done_o          = done_q;
  assign hit_o           = hit_q;
  assign frame_index_o   = 2'(idx_q);
  assign evicted_valid_o = ev_vld_q;
  assign evicted_page_o  = 16'(ev_page_q);
  assign fault_count_o   = faults_q;

  // Ranks form a permutation, so exactly one frame is oldest
  a_one_oldest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(oldest))
    else $error("recency ranks lost their unique oldest frame");

  // A hit never reports an eviction
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && hit_o |-> !evicted_valid_o)
    else $error("eviction reported on a hit");

  // A FIFO miss advances the pointer
  a_fifo_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_ref && !hit_any && (policy_q == POL_FIFO) |=> fifo_ptr_q != $past(fifo_ptr_q))
    else $error("FIFO pointer did not advance on a miss");

endmodule

/* dv/page_table_checker.sv */
// Checker for the page-frame table: keeps its own copy of frames, ranks,
// FIFO pointer, fault count and policy, predicts each request and compares.
// Depends on pfl_pkg for sizes and command/policy codes.
module page_table_checker
  import pfl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  logic              cmd_i,
  input  logic [PAGE_W-1:0] page_i,
  input  logic              pol_we_i,
  input  logic              pol_wdata_i,
  input  logic              done_i,
  input  logic              hit_i,
  input  logic [IDX_W-1:0]  frame_i,
  input  logic              evict_vld_i,
  input  logic [PAGE_W-1:0] evict_page_i,
  input  logic [31:0]       faults_i,
  output int                mismatches_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  frame;
    logic              evict_vld;
    logic [PAGE_W-1:0] evict_page;
    logic [31:0]       faults;
  } lookup_outcome_t;

  lookup_outcome_t   outcomes_q[$];

  logic [PAGE_W-1:0] pages_m [FRAMES];
  logic [FRAMES-1:0] valid_m;
  logic [RANK_W-1:0] rank_m [FRAMES];
  logic [IDX_W-1:0]  fifo_ptr_m;
  logic [31:0]       faults_m;
  logic              policy_m;
  int                mism_cnt = 0;

  assign pending_o    = outcomes_q.size();
  assign mismatches_o = mism_cnt;

  function automatic void restore_order();
    for (int i = 0; i < FRAMES; i++) rank_m[i] = RANK_W'(FRAMES - 1 - i);
    fifo_ptr_m = '0;
  endfunction

  // Make frame k most recent; frames newer than it age by one.
  function automatic void make_recent(logic [IDX_W-1:0] k);
    logic [RANK_W-1:0] prev;
    prev = rank_m[k];
    for (int i = 0; i < FRAMES; i++)
      if (i != k && rank_m[i] < prev) rank_m[i] = rank_m[i] + RANK_W'(1);
    rank_m[k] = '0;
  endfunction

  function automatic lookup_outcome_t predict_lookup(logic cmd, logic [PAGE_W-1:0] page);
    lookup_outcome_t o;
    logic            found;
    logic [IDX_W-1:0] victim;
    o = '0;
    found = 1'b0;
    victim = '0;
    if (cmd == CMD_CLEAR) begin
      valid_m = '0;
      restore_order();
      faults_m = '0;
      return o;
    end
    for (int i = 0; i < FRAMES; i++) begin
      if (!found && valid_m[i] && pages_m[i] == page) begin
        found = 1'b1;
        victim = IDX_W'(i);
      end
    end
    if (found) begin
      make_recent(victim);
      o.hit = 1'b1;
      o.frame = victim;
      o.faults = faults_m;
      return o;
    end
    if (policy_m == POL_LRU) begin
      // oldest frame has the highest rank; ties cannot occur
      for (int i = 1; i < FRAMES; i++)
        if (rank_m[i] > rank_m[victim]) victim = IDX_W'(i);
    end else begin
      victim = fifo_ptr_m;
      fifo_ptr_m = (fifo_ptr_m == IDX_W'(FRAMES - 1)) ? '0 : fifo_ptr_m + IDX_W'(1);
    end
    o.evict_vld = valid_m[victim];
    o.evict_page = valid_m[victim] ? pages_m[victim] : '0;
    pages_m[victim] = page;
    valid_m[victim] = 1'b1;
    make_recent(victim);
    if (faults_m != FAULT_MAX) faults_m = faults_m + 1;
    o.frame = victim;
    o.faults = faults_m;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    mism_cnt++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_outcome_t want;
    if (!rst_ni) begin
      valid_m = '0;
      for (int i = 0; i < FRAMES; i++) pages_m[i] = '0;
      restore_order();
      faults_m = '0;
      policy_m = POL_FIFO;
      outcomes_q.delete();
    end else begin
      // results first: a result seen now belongs to an earlier request
      if (done_i) begin
        if (outcomes_q.size() == 0) begin
          report_mismatch("result with no request waiting", 1, 0);
        end else begin
          want = outcomes_q.pop_front();
          if (hit_i !== want.hit) report_mismatch("hit", hit_i, want.hit);
          if (frame_i !== want.frame) report_mismatch("frame_index", frame_i, want.frame);
          if (evict_vld_i !== want.evict_vld)
            report_mismatch("evicted_valid", evict_vld_i, want.evict_vld);
          if (evict_page_i !== want.evict_page)
            report_mismatch("evicted_page", evict_page_i, want.evict_page);
          if (faults_i !== want.faults) report_mismatch("fault_count", faults_i, want.faults);
        end
      end
      // a request taken at this edge still sees the old policy
      if (start_i && !busy_i) outcomes_q.push_back(predict_lookup(cmd_i, page_i));
      if (pol_we_i) policy_m = pol_wdata_i;
    end
  end

endmodule

/* dv/testbench.sv */
// Top of the page-frame table testbench: clock, reset, request and policy
// stimulus, verdict. Depends on pfl_pkg, page_replacement_fifo_lru, page_table_checker.
module testbench
  import pfl_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        cmd_i;
  logic [15:0] page_number_i;
  logic        policy_we_i;
  logic        policy_wdata_i;
  logic        done_o;
  logic        hit_o;
  logic [1:0]  frame_index_o;
  logic        evicted_valid_o;
  logic [15:0] evicted_page_o;
  logic [31:0] fault_count_o;
  int          mismatches;
  int          pending;
  logic        gaps_on;

  page_replacement_fifo_lru u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .cmd_i           (cmd_i),
    .page_number_i   (page_number_i),
    .policy_we_i     (policy_we_i),
    .policy_wdata_i  (policy_wdata_i),
    .done_o          (done_o),
    .hit_o           (hit_o),
    .frame_index_o   (frame_index_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .fault_count_o   (fault_count_o)
  );

  page_table_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .cmd_i        (cmd_i),
    .page_i       (page_number_i),
    .pol_we_i     (policy_we_i),
    .pol_wdata_i  (policy_wdata_i),
    .done_i       (done_o),
    .hit_i        (hit_o),
    .frame_i      (frame_index_o),
    .evict_vld_i  (evicted_valid_o),
    .evict_page_i (evicted_page_o),
    .faults_i     (fault_count_o),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic issue(logic cmd, logic [15:0] page);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= cmd;
    page_number_i <= page;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  // Hold requests until every result is back.
  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_policy(logic pol);
    policy_we_i <= 1'b1;
    policy_wdata_i <= pol;
    @(negedge clk_i);
    policy_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    logic [15:0] pool [8];
    int          pool_n;
    int          roll;
    int          guard;
    start = 1'b0;
    cmd_i = CMD_REF;
    page_number_i = '0;
    policy_we_i = 1'b0;
    policy_wdata_i = POL_FIFO;
    gaps_on = 1'b0;
    rst_ni = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // FIFO from reset: fill, hit, wrap around, clear
    issue(CMD_REF, 16'h0000);
    issue(CMD_REF, 16'hFFFF);
    issue(CMD_REF, 16'h0000);
    issue(CMD_REF, 16'h1234);
    issue(CMD_REF, 16'hABCD);
    issue(CMD_REF, 16'h5555);
    issue(CMD_REF, 16'hFFFF);
    issue(CMD_CLEAR, 16'hFFFF);
    issue(CMD_REF, 16'h0000);
    drain();
    write_policy(POL_LRU);

    // LRU: empty frames fill in index order, then the oldest goes
    issue(CMD_CLEAR, 16'h0000);
    issue(CMD_REF, 16'h0001);
    issue(CMD_REF, 16'h0002);
    issue(CMD_REF, 16'h0003);
    issue(CMD_REF, 16'h0001);
    issue(CMD_REF, 16'h0004);
    issue(CMD_REF, 16'h0005);
    issue(CMD_REF, 16'h0003);
    issue(CMD_CLEAR, 16'h0000);
    issue(CMD_REF, 16'h00A0);
    drain();

    // FIFO pointer evicts an occupied frame while others are still empty
    write_policy(POL_FIFO);
    issue(CMD_REF, 16'h00B0);
    issue(CMD_REF, 16'h00C0);
    drain();
    write_policy(POL_LRU);
    issue(CMD_REF, 16'h7FFF);
    issue(CMD_REF, 16'h00C0);
    drain();

    // Random phases: small working sets for hits and evictions, wide pages
    // for bit coverage, rare clears; policy flips without clearing state.
    for (int ph = 0; ph < 8; ph++) begin
      write_policy(ph[0] ? POL_LRU : POL_FIFO);
      gaps_on = (ph != 7);
      pool_n = $urandom_range(2, 8);
      for (int j = 0; j < 8; j++) pool[j] = 16'($urandom);
      if (ph == 2) begin
        pool[0] = 16'h0000;
        pool[1] = 16'hFFFF;
      end
      for (int n = 0; n < 250; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) issue(CMD_CLEAR, 16'($urandom));
        else if (roll < 28) issue(CMD_REF, 16'($urandom));
        else issue(CMD_REF, pool[$urandom_range(0, pool_n - 1)]);
      end
      drain();
    end

    guard = 0;
    while (pending != 0 && guard < 100) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (4) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
